/* hdl/range_add_range_sum_tree_assert.svh */
// Assertion macros for the range add / range sum block.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef RANGE_ADD_RANGE_SUM_TREE_ASSERT_SVH
`define RANGE_ADD_RANGE_SUM_TREE_ASSERT_SVH
// implication checked every cycle outside reset
`define RAST_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);
// next-cycle implication
`define RAST_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

/* hdl/rast_pkg.sv */
// Package for the range add / range sum block: sizes, action codes, sequencer states.
// No dependencies.
package rast_pkg;
	localparam int MAX_ELEMENTS = 1024;
	localparam int ADDR_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = ADDR_W + 1;
	localparam int IDX_W = ADDR_W + 2;
	localparam int DATA_W = 64;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_SUB    = 2'd1;
	localparam logic [1:0] ACT_ASK    = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_SETUP = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_RD    = 7'b0010000,
		ST_UPD   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} rast_state_t;
endpackage

/* hdl/rast_store.sv */
// Two Fenwick coefficient memories sharing one write and one read address.
// Depends on rast_pkg.
module rast_store (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [rast_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [rast_pkg::DATA_W-1:0]  wr_b1,
	input  logic [rast_pkg::DATA_W-1:0]  wr_b2,
	input  logic [rast_pkg::ADDR_W-1:0]  rd_addr,
	output logic [rast_pkg::DATA_W-1:0]  rd_b1,
	output logic [rast_pkg::DATA_W-1:0]  rd_b2
);
	logic [rast_pkg::DATA_W-1:0] b1_mem [rast_pkg::MAX_ELEMENTS];
	logic [rast_pkg::DATA_W-1:0] b2_mem [rast_pkg::MAX_ELEMENTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			b1_mem[wr_addr] <= wr_b1;
			b2_mem[wr_addr] <= wr_b2;
		end
		rd_b1 <= b1_mem[rd_addr];
		rd_b2 <= b2_mem[rd_addr];
	end
endmodule

/* hdl/range_add_range_sum_tree.sv */
// Top level of the range add / range sum block: sequencer, shared multiplier and adders.
// Depends on rast_pkg and rast_store.
//
// Usage:
// An item (action, range_low, range_high, amount) is taken when start is high and
// busy is low. Add and subtract change every element of the clipped range; an ask
// returns range_sum with a one-cycle done strobe. Results cannot be held off.
// Storage is a pair of Fenwick coefficient arrays in one memory each, so an item
// walks at most two index chains of up to log2(count)+1 nodes, each node a memory
// read, then an update. An add, subtract or ask keeps busy high while it runs; for
// an ask, done rises in the same cycle as busy falls, and the next item can be taken
// in that cycle. An empty ask answers 0 the cycle after it is taken, and an empty or
// unused item leaves busy low.
// element_count is written on the cfg channel (cfg_ready is always high). Reset
// and every count write start a clearing pass over all 1024 entries, one entry a
// cycle, with busy high; the count write takes effect at once.
module range_add_range_sum_tree (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   action,
	input  logic [10:0]                  range_low,
	input  logic [10:0]                  range_high,
	input  logic signed [31:0]           amount,
	output logic                         done,
	output logic signed [63:0]           range_sum,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [10:0]                  cfg_data
);
	localparam int AW = rast_pkg::ADDR_W;
	localparam int CW = rast_pkg::CNT_W;
	localparam int IW = rast_pkg::IDX_W;
	localparam int DW = rast_pkg::DATA_W;

	rast_pkg::rast_state_t state_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] clr_q;
	logic          is_sum_q, phase_q, done_q;
	logic [CW-1:0] lo_q, hi_q;
	logic [DW-1:0] v_q, d1_q, prod_q, s1_q, s2_q, acc_q, sum_q;
	logic [IW-1:0] idx_q;

	logic [CW-1:0] lo_c, hi_c, x_c, cfg_n;
	logic          empty_c, accept, cfg_wr;
	logic [DW-1:0] amt_c, v_c, sgn_c, mul_a, term_c;
	logic [IW-1:0] idx0_c, lowbit, idx_up, idx_dn;
	logic [DW-1:0] rd_b1, rd_b2;
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [DW-1:0] wr_b1, wr_b2;

	assign busy = (state_q != rast_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid;
	assign done = done_q;
	assign range_sum = sum_q;

	always_comb begin
		if (cfg_data == '0) cfg_n = CW'(1);
		else if (cfg_data > CW'(rast_pkg::MAX_ELEMENTS)) cfg_n = CW'(rast_pkg::MAX_ELEMENTS);
		else cfg_n = cfg_data;
		lo_c = (range_low == '0) ? CW'(1) : range_low;
		hi_c = (range_high > n_q) ? n_q : range_high;
		empty_c = lo_c > hi_c;
		amt_c = DW'(amount);
		v_c = (action == rast_pkg::ACT_SUB) ? (DW'(0) - amt_c) : amt_c;
		if (is_sum_q) x_c = phase_q ? (lo_q - CW'(1)) : hi_q;
		else x_c = phase_q ? hi_q : (lo_q - CW'(1));
		if (is_sum_q) idx0_c = IW'(x_c);
		else idx0_c = phase_q ? (IW'(hi_q) + IW'(1)) : IW'(lo_q);
		sgn_c = phase_q ? (DW'(0) - v_q) : v_q;
		mul_a = is_sum_q ? s1_q : sgn_c;
		lowbit = idx_q & (~idx_q + IW'(1));
		idx_up = idx_q + lowbit;
		idx_dn = idx_q - lowbit;
		term_c = prod_q - s2_q;
	end

	assign rd_addr = AW'(idx_q - IW'(1));
	assign wr_en = (state_q == rast_pkg::ST_CLEAR) || (state_q == rast_pkg::ST_UPD && !is_sum_q);
	assign wr_addr = (state_q == rast_pkg::ST_CLEAR) ? clr_q : rd_addr;
	assign wr_b1 = (state_q == rast_pkg::ST_CLEAR) ? '0 : (rd_b1 + d1_q);
	assign wr_b2 = (state_q == rast_pkg::ST_CLEAR) ? '0 : (rd_b2 + prod_q);

	rast_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_b1   (wr_b1),
		.wr_b2   (wr_b2),
		.rd_addr (rd_addr),
		.rd_b1   (rd_b1),
		.rd_b2   (rd_b2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rast_pkg::ST_CLEAR;
			n_q <= CW'(rast_pkg::MAX_ELEMENTS);
			clr_q <= '0;
			is_sum_q <= 1'b0;
			phase_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				n_q <= cfg_n;
				clr_q <= '0;
				state_q <= rast_pkg::ST_CLEAR;
			end else begin
				case (state_q)
					rast_pkg::ST_IDLE: begin
						if (accept) begin
							phase_q <= 1'b0;
							is_sum_q <= (action == rast_pkg::ACT_ASK);
							if (action == rast_pkg::ACT_ASK && empty_c) begin
								done_q <= 1'b1;
							end else if (!empty_c && action != rast_pkg::ACT_UNUSED) begin
								state_q <= rast_pkg::ST_SETUP;
							end
						end
					end
					rast_pkg::ST_CLEAR: begin
						clr_q <= clr_q + AW'(1);
						if (clr_q == AW'(rast_pkg::MAX_ELEMENTS - 1)) state_q <= rast_pkg::ST_IDLE;
					end
					rast_pkg::ST_SETUP: begin
						if (is_sum_q && idx0_c != '0) state_q <= rast_pkg::ST_RD;
						else state_q <= rast_pkg::ST_MUL;
					end
					rast_pkg::ST_MUL: begin
						if (is_sum_q) state_q <= rast_pkg::ST_FIN;
						else if (idx_q <= IW'(n_q)) state_q <= rast_pkg::ST_RD;
						else if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= rast_pkg::ST_SETUP;
						end else state_q <= rast_pkg::ST_IDLE;
					end
					rast_pkg::ST_RD: state_q <= rast_pkg::ST_UPD;
					rast_pkg::ST_UPD: begin
						if (is_sum_q) begin
							state_q <= (idx_dn == '0) ? rast_pkg::ST_MUL : rast_pkg::ST_RD;
						end else if (idx_up <= IW'(n_q)) state_q <= rast_pkg::ST_RD;
						else if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= rast_pkg::ST_SETUP;
						end else state_q <= rast_pkg::ST_IDLE;
					end
					rast_pkg::ST_FIN: begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= rast_pkg::ST_SETUP;
						end else begin
							done_q <= 1'b1;
							state_q <= rast_pkg::ST_IDLE;
						end
					end
					default: state_q <= rast_pkg::ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rast_pkg::ST_IDLE: begin
				lo_q <= lo_c;
				hi_q <= hi_c;
				v_q <= v_c;
				if (accept) sum_q <= '0;
			end
			rast_pkg::ST_SETUP: begin
				idx_q <= idx0_c;
				s1_q <= '0;
				s2_q <= '0;
			end
			rast_pkg::ST_MUL: begin
				prod_q <= mul_a * DW'(x_c);
				d1_q <= sgn_c;
			end
			rast_pkg::ST_UPD: begin
				if (is_sum_q) begin
					s1_q <= s1_q + rd_b1;
					s2_q <= s2_q + rd_b2;
					idx_q <= idx_dn;
				end else idx_q <= idx_up;
			end
			rast_pkg::ST_FIN: begin
				acc_q <= term_c;
				if (phase_q) sum_q <= acc_q - term_c;
			end
			default: ;
		endcase
	end
endmodule

/* hdl/rast_checker.sv */
// Port-level checks for the range add / range sum block, bound to the top level.
// Depends on rast_pkg and range_add_range_sum_tree_assert.svh.
`include "range_add_range_sum_tree_assert.svh"
module rast_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  action,
	input logic        done,
	input logic        cfg_valid,
	input logic        cfg_ready
);
	`RAST_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
	`RAST_ASSERT_NXT(a_no_result_update, start && !busy && action != rast_pkg::ACT_ASK, !done, "result for non-ask item")
	`RAST_ASSERT_NXT(a_cfg_clears, cfg_valid && cfg_ready, busy, "count write did not start clearing")
	`RAST_ASSERT_NXT(a_busy_no_done, busy && !cfg_valid && $past(busy), !($rose(busy)), "busy rose while busy")
endmodule

bind range_add_range_sum_tree rast_checker u_rast_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.action    (action),
	.done      (done),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
